// ----- rtl/core/ibfc_pkg.sv -----
// Shared types and constants for the idle backlight fade controller.
`timescale 1ns / 1ps

package ibfc_pkg;

    localparam int STEP_BITS  = 10;
    localparam int IDLE_W     = 22;
    localparam int CNT_W      = 10;
    localparam int LVL_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int STEP_CMP_W = (STEP_BITS > CNT_W) ? STEP_BITS : CNT_W;

    // Divider sizing: remaining steps times one hundred over the step count.
    localparam int DVD_W  = 17;
    localparam int DVS_W  = 10;
    localparam int DCNT_W = $clog2(DVD_W);
    localparam int PCT_W  = 7;

    // Division by one hundred through a reciprocal, exact for dividends below 43690.
    localparam int MUL_A_W     = 15;
    localparam int MUL_B_W     = 13;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int RECIP_SHIFT = 19;
    localparam logic [MUL_B_W-1:0] RECIP_100 = 13'd5243;
    localparam logic [DVD_W-1:0]   PCT_SCALE = 17'd100;

    localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};
    localparam logic [IDLE_W-1:0]    IDLE_MAX = {IDLE_W{1'b1}};

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEPS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD = 2'd3;

    localparam logic ACTION_TICK     = 1'b0;
    localparam logic ACTION_ACTIVITY = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_EVAL,
        OP_DIV_GO,
        OP_SQ,
        OP_E1,
        OP_E2,
        OP_D1,
        OP_D2,
        OP_D3,
        OP_L1,
        OP_L2,
        OP_L3,
        OP_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   capture;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_step;
        logic div_done;
    } dp_status_t;

endpackage

// ----- rtl/core/ibfc_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ibfc_div import ibfc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic              busy_reg;
    logic [DCNT_W-1:0] count_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  part_reg;
    logic [DVS_W-1:0]  divisor_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    assign trial = {part_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};
    assign done  = busy_reg && (count_reg == DCNT_W'(DVD_W - 1));
    // The dividend register fills with quotient bits from the bottom.
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end else if (busy_reg) begin
            count_reg <= count_reg + 1'b1;
            if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg     <= dividend;
            part_reg    <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            part_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_reg  <= {dvd_reg[DVD_W-2:0], fits};
        end
    end

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

endmodule

// ----- rtl/core/ibfc_datapath.sv -----
// Datapath: configuration, idle and fade state, shared multiplier and divider.
`timescale 1ns / 1ps

module ibfc_datapath import ibfc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_action,
    input  logic [LVL_W-1:0]      in_led_value,
    input  logic [LVL_W-1:0]      in_display_level,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic [M_TDATA_W-1:0]  result_word
);

    // Configuration.
    logic [IDLE_W-1:0] idle_timeout_reg;
    logic [CNT_W-1:0]  fade_steps_reg;
    logic [CNT_W-1:0]  fade_interval_reg;
    logic [LVL_W-1:0]  off_threshold_reg;

    // Captured request.
    logic             action_reg;
    logic [LVL_W-1:0] cur_led_reg;
    logic [LVL_W-1:0] cur_disp_reg;

    // Controller state.
    logic [IDLE_W-1:0]    idle_count_reg;
    logic [CNT_W-1:0]     interval_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 fade_reg;
    logic                 led_on_reg;
    logic                 disp_on_reg;
    logic [LVL_W-1:0]     led_base_reg;
    logic [LVL_W-1:0]     led_restore_reg;
    logic [LVL_W-1:0]     disp_saved_reg;
    logic [LVL_W-1:0]     led_now_reg;
    logic [LVL_W-1:0]     disp_now_reg;

    // Step working registers.
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     steps_reg;
    logic                 in_range_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PCT_W-1:0]     eased_reg;
    logic [M_TDATA_W-1:0] result_word_reg;

    logic [CNT_W-1:0]      steps_eff;
    logic [IDLE_W-1:0]     idle_inc;
    logic                  start_fade;
    logic [CNT_W-1:0]      interval_base;
    logic [STEP_BITS-1:0]  step_base;
    logic [STEP_BITS-1:0]  step_inc;
    logic                  fade_after;
    logic                  take_step;
    logic                  in_range;
    logic [CNT_W-1:0]      rem_val;
    logic [STEP_CMP_W-1:0] steps_cmp;
    logic [STEP_CMP_W-1:0] step_cmp;
    logic [LVL_W-1:0]      restore_max;
    logic                  div_done;
    logic [DVD_W-1:0]      quotient;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic                  led_off;
    logic                  disp_off;
    logic                  timeout_active;

    assign steps_eff     = (fade_steps_reg == '0) ? CNT_W'(1) : fade_steps_reg;
    assign idle_inc      = (idle_count_reg == IDLE_MAX) ? idle_count_reg
                                                        : idle_count_reg + 1'b1;
    assign start_fade    = (led_on_reg || disp_on_reg) && !fade_reg
                           && (idle_inc > idle_timeout_reg);
    assign interval_base = start_fade ? '0 : interval_reg;
    assign step_base     = start_fade ? '0 : step_reg;
    assign fade_after    = fade_reg || start_fade;
    assign take_step     = (action_reg == ACTION_TICK) && fade_after
                           && (interval_base >= fade_interval_reg);
    assign step_inc      = (step_base == STEP_MAX) ? step_base : step_base + 1'b1;
    assign steps_cmp     = STEP_CMP_W'(steps_eff);
    assign step_cmp      = STEP_CMP_W'(step_inc);
    assign in_range      = step_cmp <= steps_cmp;
    assign rem_val       = (steps_cmp > step_cmp) ? CNT_W'(steps_cmp - step_cmp) : '0;
    assign restore_max   = (cur_led_reg > led_restore_reg) ? cur_led_reg : led_restore_reg;

    assign status.need_step = take_step;
    assign status.div_done  = div_done;

    ibfc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == OP_DIV_GO),
        .dividend (DVD_W'(rem_reg) * PCT_SCALE),
        .divisor  (steps_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // One multiplier serves the squaring, the scaling and the reciprocal steps.
    always_comb begin
        mul_a = prod_reg[MUL_A_W-1:0];
        mul_b = RECIP_100;
        case (cmd.op)
            OP_SQ: begin
                mul_a = MUL_A_W'(quotient[PCT_W-1:0]);
                mul_b = MUL_B_W'(quotient[PCT_W-1:0]);
            end
            OP_D1: begin
                mul_a = MUL_A_W'(disp_saved_reg);
                mul_b = MUL_B_W'(eased_reg);
            end
            OP_L1: begin
                mul_a = MUL_A_W'(led_base_reg);
                mul_b = MUL_B_W'(eased_reg);
            end
            default: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = RECIP_100;
            end
        endcase
    end

    assign led_off  = in_range_reg && led_on_reg && (led_now_reg <= off_threshold_reg);
    assign disp_off = in_range_reg && disp_on_reg && (disp_now_reg <= off_threshold_reg);
    assign timeout_active = fade_reg || (!led_on_reg && !disp_on_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg  <= IDLE_W'(60000);
            fade_steps_reg    <= CNT_W'(312);
            fade_interval_reg <= CNT_W'(16);
            off_threshold_reg <= LVL_W'(2);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IDLE_TIMEOUT:  idle_timeout_reg  <= cfg_wdata[IDLE_W-1:0];
                CFG_FADE_STEPS:    fade_steps_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_FADE_INTERVAL: fade_interval_reg <= cfg_wdata[CNT_W-1:0];
                CFG_OFF_THRESHOLD: off_threshold_reg <= cfg_wdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_count_reg  <= '0;
            interval_reg    <= '0;
            step_reg        <= '0;
            fade_reg        <= 1'b0;
            led_on_reg      <= 1'b1;
            disp_on_reg     <= 1'b1;
            led_base_reg    <= '1;
            led_restore_reg <= '1;
            disp_saved_reg  <= '1;
            led_now_reg     <= '1;
            disp_now_reg    <= '1;
        end else begin
            case (cmd.op)
                OP_EVAL: begin
                    if (action_reg == ACTION_TICK) begin
                        idle_count_reg <= idle_inc;
                        fade_reg       <= fade_after;
                        if (start_fade) begin
                            led_base_reg   <= cur_led_reg;
                            disp_saved_reg <= cur_disp_reg;
                        end
                        if (fade_after) begin
                            if (take_step) begin
                                interval_reg <= '0;
                                step_reg     <= step_inc;
                            end else begin
                                interval_reg <= interval_base + 1'b1;
                                step_reg     <= step_base;
                            end
                        end
                    end else begin
                        // Activity always leaves both lights on and no fade running.
                        idle_count_reg  <= '0;
                        fade_reg        <= 1'b0;
                        led_on_reg      <= 1'b1;
                        disp_on_reg     <= 1'b1;
                        led_restore_reg <= restore_max;
                        led_base_reg    <= restore_max;
                        if (!led_on_reg) begin
                            led_now_reg <= led_restore_reg;
                        end
                        if (!disp_on_reg) begin
                            disp_now_reg <= disp_saved_reg;
                        end
                    end
                end
                OP_D3: disp_now_reg <= prod_reg[RECIP_SHIFT+LVL_W-1:RECIP_SHIFT];
                OP_L3: begin
                    if (in_range_reg && led_on_reg) begin
                        led_now_reg <= prod_reg[RECIP_SHIFT+LVL_W-1:RECIP_SHIFT];
                    end
                end
                OP_FIN: begin
                    led_on_reg  <= led_on_reg && !led_off;
                    disp_on_reg <= disp_on_reg && !disp_off;
                    if (!(led_on_reg && !led_off) && !(disp_on_reg && !disp_off)) begin
                        fade_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg   <= in_action;
            cur_led_reg  <= in_led_value;
            cur_disp_reg <= in_display_level;
        end
        if (cmd.op == OP_EVAL && take_step) begin
            rem_reg      <= rem_val;
            steps_reg    <= steps_eff;
            in_range_reg <= in_range;
        end
        if (cmd.op == OP_SQ || cmd.op == OP_E1 || cmd.op == OP_D1 || cmd.op == OP_D2
            || cmd.op == OP_L1 || cmd.op == OP_L2) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.op == OP_E2) begin
            eased_reg <= prod_reg[RECIP_SHIFT+PCT_W-1:RECIP_SHIFT];
        end
        if (cmd.load_out) begin
            result_word_reg <= {4'b0000, timeout_active, fade_reg, disp_on_reg,
                                disp_now_reg, led_on_reg, led_now_reg};
        end
    end

    assign result_word = result_word_reg;

    a_fade_has_light: assert property (@(posedge aclk) disable iff (!aresetn)
        fade_reg |-> (led_on_reg || disp_on_reg))
        else $error("fade running with both lights off");

    a_activity_restores: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EVAL && action_reg == ACTION_ACTIVITY)
        |=> (led_on_reg && disp_on_reg && !fade_reg && idle_count_reg == '0))
        else $error("activity did not restore the lights");

endmodule

// ----- rtl/core/ibfc_ctrl.sv -----
// Controller state machine sequencing evaluation, fade step arithmetic and output.
`timescale 1ns / 1ps

module ibfc_ctrl import ibfc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SQ,
        S_E1,
        S_E2,
        S_D1,
        S_D2,
        S_D3,
        S_L1,
        S_L2,
        S_L3,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   s_accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.capture  = s_accept;
        cmd.load_out = (state_reg == S_OUT) && out_free;
        case (state_reg)
            S_EVAL:   cmd.op = OP_EVAL;
            S_DIV_GO: cmd.op = OP_DIV_GO;
            S_SQ:     cmd.op = OP_SQ;
            S_E1:     cmd.op = OP_E1;
            S_E2:     cmd.op = OP_E2;
            S_D1:     cmd.op = OP_D1;
            S_D2:     cmd.op = OP_D2;
            S_D3:     cmd.op = OP_D3;
            S_L1:     cmd.op = OP_L1;
            S_L2:     cmd.op = OP_L2;
            S_L3:     cmd.op = OP_L3;
            S_FIN:    cmd.op = OP_FIN;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:     if (s_accept) state_reg <= S_EVAL;
                S_EVAL:     state_reg <= status.need_step ? S_DIV_GO : S_OUT;
                S_DIV_GO:   state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: if (status.div_done) state_reg <= S_SQ;
                S_SQ:       state_reg <= S_E1;
                S_E1:       state_reg <= S_E2;
                S_E2:       state_reg <= S_D1;
                S_D1:       state_reg <= S_D2;
                S_D2:       state_reg <= S_D3;
                S_D3:       state_reg <= S_L1;
                S_L1:       state_reg <= S_L2;
                S_L2:       state_reg <= S_L3;
                S_L3:       state_reg <= S_FIN;
                S_FIN:      state_reg <= S_OUT;
                S_OUT:      if (out_free) state_reg <= S_IDLE;
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("second request taken while one is in work");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result register overwritten before it was taken");

    a_div_to_square: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV_WAIT && status.div_done) |=> (state_reg == S_SQ))
        else $error("divider finish not followed by squaring");

endmodule

// ----- rtl/core/idle_backlight_fade_controller.sv -----
// Top level of the idle backlight fade controller.
//
//  Channel   Direction  Payload
//  s_*       in         tuser: action; tdata: current_led_value, current_display_level
//  m_*       out        tdata: led_level .. timeout_active, one result per request
//  cfg_*     in         plain register writes, index 0..3
//
// A request that needs no fade step goes from evaluation straight to the output state,
// where its result is loaded into the output register once that register is free.
// A fade step first runs the serial divider for the percentage and then six shared multiplier
// passes (square, ease, two for the display level, two for the LED level) before output.
// One request is worked on at a time; a new one is taken while a result waits.
// Reset is synchronous and active low and restores configuration and state at once.
`timescale 1ns / 1ps

module idle_backlight_fade_controller import ibfc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: current_led_value [7:0], current_display_level [15:8]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: action [0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: led_level [7:0], led_enabled [8], display_level [16:9],
    // display_enabled [17], fading [18], timeout_active [19], zero [23:20]
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ibfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ibfc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_action        (s_tuser),
        .in_led_value     (s_tdata[LVL_W-1:0]),
        .in_display_level (s_tdata[2*LVL_W-1:LVL_W]),
        .cmd              (cmd),
        .status           (status),
        .result_word      (m_tdata)
    );

endmodule
